// ===== hdl/jsu_pkg.sv =====
// Shared types and codes for the JSON string unescaper.
// Used by jsu_decode and json_string_unescape_top; depends on nothing.

package jsu_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5,
        PH_HEX4 = 3'd6
    } phase_t;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_CTRL    = 3'd2;
    localparam logic [2:0] ERR_ESC     = 3'd3;
    localparam logic [2:0] ERR_UNI     = 3'd4;
    localparam logic [2:0] ERR_UNTERM  = 3'd5;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;
    localparam int unsigned CP_PART_W   = 12;

    // One burst of results caused by a single input item. All results in a
    // burst share the flags; only decoded bytes come in bursts longer than one.
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [MAX_RESULTS-1:0][7:0]     bytes;
        logic                            byte_valid;
        logic                            done;
        logic [2:0]                      err;
    } burst_t;

endpackage

// ===== hdl/jsu_decode.sv =====
// Combinational decode of one input item against the current phase.
// Produces the next phase, the next partial code point and the result burst.
// Depends on jsu_pkg.

module jsu_decode (
    input  jsu_pkg::phase_t                      phase,
    input  logic [jsu_pkg::CP_PART_W-1:0]        partial_cp,
    input  logic [7:0]                           data_byte,
    input  logic                                 input_end,
    output jsu_pkg::phase_t                      phase_next,
    output logic [jsu_pkg::CP_PART_W-1:0]        partial_cp_next,
    output jsu_pkg::burst_t                      burst
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic       esc_ok;
    logic [7:0] esc_val;
    logic [15:0] cp;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
            hex_val = 4'(data_byte - 8'h30);
        end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
            hex_val = 4'(data_byte - 8'h57);
        end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
            hex_val = 4'(data_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = 8'h00;
        unique case (data_byte)
            8'h22: esc_val = 8'h22;
            8'h5C: esc_val = 8'h5C;
            8'h2F: esc_val = 8'h2F;
            8'h62: esc_val = 8'h08;
            8'h66: esc_val = 8'h0C;
            8'h6E: esc_val = 8'h0A;
            8'h72: esc_val = 8'h0D;
            8'h74: esc_val = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign cp = {partial_cp, hex_val};

    // Next state
    always_comb begin
        phase_next      = phase;
        partial_cp_next = partial_cp;
        if (input_end) begin
            phase_next      = jsu_pkg::PH_WAIT;
            partial_cp_next = '0;
        end else begin
            unique case (phase)
                jsu_pkg::PH_WAIT: begin
                    partial_cp_next = '0;
                    phase_next = (data_byte == CH_QUOTE) ? jsu_pkg::PH_BODY
                                                         : jsu_pkg::PH_WAIT;
                end
                jsu_pkg::PH_BODY: begin
                    if (data_byte == CH_QUOTE || data_byte < 8'h20) begin
                        phase_next      = jsu_pkg::PH_WAIT;
                        partial_cp_next = '0;
                    end else if (data_byte == CH_BSL) begin
                        phase_next = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (data_byte == CH_U) begin
                        phase_next      = jsu_pkg::PH_HEX1;
                        partial_cp_next = '0;
                    end else if (esc_ok) begin
                        phase_next = jsu_pkg::PH_BODY;
                    end else begin
                        phase_next      = jsu_pkg::PH_WAIT;
                        partial_cp_next = '0;
                    end
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
                    if (hex_ok) begin
                        partial_cp_next = cp[jsu_pkg::CP_PART_W-1:0];
                        phase_next      = jsu_pkg::phase_t'(phase + 3'd1);
                    end else begin
                        phase_next      = jsu_pkg::PH_WAIT;
                        partial_cp_next = '0;
                    end
                end
                jsu_pkg::PH_HEX4: begin
                    phase_next      = hex_ok ? jsu_pkg::PH_BODY : jsu_pkg::PH_WAIT;
                    partial_cp_next = '0;
                end
                // unused code behaves as waiting for the opening quote
                default: begin
                    partial_cp_next = '0;
                    phase_next = (data_byte == CH_QUOTE) ? jsu_pkg::PH_BODY
                                                         : jsu_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Result burst
    always_comb begin
        burst            = '0;
        burst.err        = jsu_pkg::ERR_NONE;
        if (input_end) begin
            burst.count = 2'd1;
            unique case (phase)
                jsu_pkg::PH_BODY: burst.err = jsu_pkg::ERR_UNTERM;
                jsu_pkg::PH_ESC:  burst.err = jsu_pkg::ERR_ESC;
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
                jsu_pkg::PH_HEX4: burst.err = jsu_pkg::ERR_UNI;
                default:          burst.err = jsu_pkg::ERR_QUOTE;
            endcase
        end else begin
            unique case (phase)
                jsu_pkg::PH_WAIT: begin
                    if (data_byte != CH_QUOTE) begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_QUOTE;
                    end
                end
                jsu_pkg::PH_BODY: begin
                    if (data_byte == CH_QUOTE) begin
                        burst.count = 2'd1;
                        burst.done  = 1'b1;
                    end else if (data_byte < 8'h20) begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_CTRL;
                    end else if (data_byte != CH_BSL) begin
                        burst.count      = 2'd1;
                        burst.byte_valid = 1'b1;
                        burst.bytes[0]   = data_byte;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (data_byte == CH_U) begin
                        burst.count = 2'd0;
                    end else if (esc_ok) begin
                        burst.count      = 2'd1;
                        burst.byte_valid = 1'b1;
                        burst.bytes[0]   = esc_val;
                    end else begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_ESC;
                    end
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
                    if (!hex_ok) begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_UNI;
                    end
                end
                jsu_pkg::PH_HEX4: begin
                    if (!hex_ok) begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_UNI;
                    end else if (cp <= 16'h007F) begin
                        burst.count      = 2'd1;
                        burst.byte_valid = 1'b1;
                        burst.bytes[0]   = cp[7:0];
                    end else if (cp <= 16'h07FF) begin
                        burst.count      = 2'd2;
                        burst.byte_valid = 1'b1;
                        burst.bytes[0]   = 8'hC0 | {3'b000, cp[10:6]};
                        burst.bytes[1]   = 8'h80 | {2'b00, cp[5:0]};
                    end else begin
                        burst.count      = 2'd3;
                        burst.byte_valid = 1'b1;
                        burst.bytes[0]   = 8'hE0 | {4'b0000, cp[15:12]};
                        burst.bytes[1]   = 8'h80 | {2'b00, cp[11:6]};
                        burst.bytes[2]   = 8'h80 | {2'b00, cp[5:0]};
                    end
                end
                default: begin
                    if (data_byte != CH_QUOTE) begin
                        burst.count = 2'd1;
                        burst.err   = jsu_pkg::ERR_QUOTE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/json_string_unescape_top.sv =====
// Top level of the JSON string unescaper: stream ports, parser state and
// the result burst register. Depends on jsu_pkg and jsu_decode.

// Feed a quoted JSON string one byte per item, opening quote first; set
// s_tuser to mark end of input instead of a byte. Each item is decoded in
// the cycle it is accepted and its results (zero to three) land in one
// burst register that drains one result per cycle on the master side while
// m_tready is high. A new item is taken every cycle as long as each one yields
// at most one result and m_tready stays high; a \u escape whose code point
// needs two or three UTF-8 bytes holds the input while the burst drains.
// m_tlast marks the final result caused by an input item. After a closing
// quote or any error the block waits for a new opening quote.

module json_string_unescape_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] input_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [7:0] m_tuser,   // [0] byte_valid, [1] string_done,
                                  // [4:2] error_code, [7:5] zero
    output logic       m_tlast    // last_of_run
);

    jsu_pkg::phase_t                    phase_reg, phase_next, dec_phase;
    logic [jsu_pkg::CP_PART_W-1:0]      pcp_reg, pcp_next, dec_pcp;
    jsu_pkg::burst_t                    burst_reg, burst_next, dec_burst;
    logic                               busy_reg, busy_next;
    logic [jsu_pkg::CNT_W-1:0]          idx_reg, idx_next;

    logic s_fire;
    logic m_fire;
    logic last_out;

    jsu_decode u_decode (
        .phase           (phase_reg),
        .partial_cp      (pcp_reg),
        .data_byte       (s_tdata),
        .input_end       (s_tuser),
        .phase_next      (dec_phase),
        .partial_cp_next (dec_pcp),
        .burst           (dec_burst)
    );

    assign last_out = (idx_reg == jsu_pkg::CNT_W'(burst_reg.count - 2'd1));
    assign s_tready = !busy_reg || (m_tready && last_out);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = busy_reg && m_tready;

    assign m_tvalid = busy_reg;
    assign m_tdata  = burst_reg.bytes[idx_reg];
    assign m_tuser  = {3'b000, burst_reg.err, burst_reg.done, burst_reg.byte_valid};
    assign m_tlast  = last_out;

    always_comb begin
        phase_next = phase_reg;
        pcp_next   = pcp_reg;
        burst_next = burst_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        // advance or retire the burst being drained
        if (m_fire) begin
            if (last_out) begin
                busy_next = 1'b0;
                idx_next  = '0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (s_fire) begin
            phase_next = dec_phase;
            pcp_next   = dec_pcp;
            if (dec_burst.count != 2'd0) begin
                burst_next = dec_burst;
                busy_next  = 1'b1;
                idx_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= jsu_pkg::PH_WAIT;
            pcp_reg   <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pcp_reg   <= pcp_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        burst_reg <= burst_next;
    end

endmodule
